// ===== src/cpuexe_pkg.sv =====
`timescale 1ns / 1ps
package cpuexe_pkg;

    localparam int QueueDepth = 2;

    typedef enum logic [4:0] {
        CMD_NOP      = 5'd0,
        CMD_LD_R     = 5'd1,
        CMD_LD_A_BC  = 5'd2,
        CMD_LD_A_DE  = 5'd3,
        CMD_LD_BC_A  = 5'd4,
        CMD_LD_DE_A  = 5'd5,
        CMD_LD_A_HLI = 5'd6,
        CMD_LD_A_HLD = 5'd7,
        CMD_LD_HLI_A = 5'd8,
        CMD_LD_HLD_A = 5'd9,
        CMD_LD_A_NN  = 5'd10,
        CMD_LD_NN_A  = 5'd11,
        CMD_LD_A_IOC = 5'd12,
        CMD_LD_IOC_A = 5'd13,
        CMD_LDH_A_N  = 5'd14,
        CMD_LDH_N_A  = 5'd15,
        CMD_LD_RR_NN = 5'd16,
        CMD_LD_SP_HL = 5'd17,
        CMD_LD_HL_SP = 5'd18,
        CMD_LD_NN_SP = 5'd19,
        CMD_PUSH     = 5'd20,
        CMD_POP      = 5'd21,
        CMD_ADD      = 5'd22,
        CMD_ADC      = 5'd23,
        CMD_SUB      = 5'd24,
        CMD_INC      = 5'd25,
        CMD_DEC      = 5'd26,
        CMD_ILL27    = 5'd27,
        CMD_ILL28    = 5'd28,
        CMD_ILL29    = 5'd29,
        CMD_ILL30    = 5'd30,
        CMD_ILL31    = 5'd31
    } cmd_t;

    localparam logic [2:0] ACC_NONE = 3'd0;
    localparam logic [2:0] ACC_RD8  = 3'd1;
    localparam logic [2:0] ACC_RD16 = 3'd2;
    localparam logic [2:0] ACC_WR8  = 3'd3;
    localparam logic [2:0] ACC_WR16 = 3'd4;

    localparam logic [2:0] SEL_MEM = 3'd6;
    localparam logic [1:0] PAIR_HL = 2'd2;
    localparam logic [1:0] PAIR_LAST = 2'd3;
    localparam logic [15:0] IO_PAGE = 16'hFF00;

    // Decoded request as it sits in the queue
    typedef struct packed {
        cmd_t        cmd;
        logic [2:0]  dst;
        logic        src_imm;
        logic [2:0]  src;
        logic [1:0]  pair;
        logic [15:0] imm;
        logic [15:0] mdata;
    } op_t;

    typedef struct packed {
        logic [2:0]  acc;
        logic [15:0] addr;
        logic [15:0] wdata;
        logic [7:0]  a;
        logic [7:0]  f;
        logic [15:0] bc;
        logic [15:0] de;
        logic [15:0] hl;
        logic [15:0] sp;
    } res_t;

endpackage

// ===== src/cpuexe_front.sv =====
`timescale 1ns / 1ps
module cpuexe_front
    import cpuexe_pkg::*;
#(
    parameter int Depth = QueueDepth
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [4:0]  in_cmd,
    input  logic [2:0]  in_dst,
    input  logic [3:0]  in_src,
    input  logic [1:0]  in_pair,
    input  logic [15:0] in_imm,
    input  logic [15:0] in_mdata,
    output logic        q_valid,
    input  logic        q_ready,
    output op_t         q_op
);
    localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

    op_t            mem_reg [Depth];
    logic [AW-1:0]  wr_reg, rd_reg;
    logic [AW:0]    cnt_reg;
    op_t            op_in;
    logic           push, pop;

    always_comb begin
        op_in.cmd     = cmd_t'(in_cmd);
        op_in.dst     = in_dst;
        op_in.src_imm = in_src[3];
        op_in.src     = in_src[2:0];
        op_in.pair    = in_pair;
        op_in.imm     = in_imm;
        op_in.mdata   = in_mdata;
    end

    assign in_ready = (cnt_reg != (AW+1)'(Depth));
    assign q_valid  = (cnt_reg != '0);
    assign q_op     = mem_reg[rd_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_reg] <= op_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wr_reg <= (wr_reg == AW'(Depth - 1)) ? '0 : wr_reg + 1'b1;
            end
            if (pop) begin
                rd_reg <= (rd_reg == AW'(Depth - 1)) ? '0 : rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end
endmodule

// ===== src/cpuexe_back.sv =====
`timescale 1ns / 1ps
module cpuexe_back
    import cpuexe_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic q_valid,
    output logic q_ready,
    input  op_t  q_op,
    output logic out_valid,
    input  logic out_ready,
    output res_t out_res
);
    // register file: B C D E H L F A
    logic [7:0]  rf_reg [8];
    logic [7:0]  rf_next [8];
    logic [15:0] sp_reg, sp_next;
    logic        vld_reg;
    res_t        res_reg;
    res_t        res_c;
    logic        fire;

    assign q_ready   = !vld_reg || out_ready;
    assign fire      = q_valid && q_ready;
    assign out_valid = vld_reg;
    assign out_res   = res_reg;

    function automatic logic [15:0] pair_of(input logic [7:0] r [8], input logic [1:0] p);
        logic [15:0] w;
        unique case (p)
            2'd0:    w = {r[0], r[1]};
            2'd1:    w = {r[2], r[3]};
            2'd2:    w = {r[4], r[5]};
            default: w = {r[7], r[6]};
        endcase
        return w;
    endfunction

    always_comb begin
        logic [15:0] hl, ext, nhl;
        logic [7:0]  a, ib, mb, v, old, nw;
        logic [8:0]  s;
        logic [4:0]  hs;
        logic        cin, cf, mem_src;
        for (int i = 0; i < 8; i++) rf_next[i] = rf_reg[i];
        sp_next = sp_reg;
        hl  = {rf_reg[4], rf_reg[5]};
        a   = rf_reg[7];
        ib  = q_op.imm[7:0];
        mb  = q_op.mdata[7:0];
        cf  = rf_reg[6][4];
        res_c.acc   = ACC_NONE;
        res_c.addr  = '0;
        res_c.wdata = '0;
        mem_src = !q_op.src_imm && (q_op.src == SEL_MEM);
        v   = q_op.src_imm ? ib : (mem_src ? mb : rf_reg[q_op.src]);
        old = (q_op.dst == SEL_MEM) ? mb : rf_reg[q_op.dst];
        ext = {{8{ib[7]}}, ib};
        nhl = (q_op.cmd == CMD_LD_A_HLI || q_op.cmd == CMD_LD_HLI_A) ? hl + 16'd1 : hl - 16'd1;
        s = '0; hs = '0; cin = 1'b0; nw = '0;
        unique case (q_op.cmd)
            CMD_LD_R: begin
                if (!(q_op.dst == SEL_MEM && mem_src)) begin
                    if (mem_src) begin
                        res_c.acc = ACC_RD8; res_c.addr = hl;
                    end
                    if (q_op.dst == SEL_MEM) begin
                        res_c.acc = ACC_WR8; res_c.addr = hl; res_c.wdata = {8'h00, v};
                    end else begin
                        rf_next[q_op.dst] = v;
                    end
                end
            end
            CMD_LD_A_BC, CMD_LD_A_DE: begin
                res_c.acc  = ACC_RD8;
                res_c.addr = pair_of(rf_reg, {1'b0, q_op.cmd[0] ^ 1'b0 ? 1'b1 : 1'b0});
                rf_next[7] = mb;
            end
            CMD_LD_BC_A, CMD_LD_DE_A: begin
                res_c.acc   = ACC_WR8;
                res_c.addr  = pair_of(rf_reg, {1'b0, q_op.cmd == CMD_LD_DE_A});
                res_c.wdata = {8'h00, a};
            end
            CMD_LD_A_HLI, CMD_LD_A_HLD: begin
                res_c.acc = ACC_RD8; res_c.addr = hl; rf_next[7] = mb;
                {rf_next[4], rf_next[5]} = nhl;
            end
            CMD_LD_HLI_A, CMD_LD_HLD_A: begin
                res_c.acc = ACC_WR8; res_c.addr = hl; res_c.wdata = {8'h00, a};
                {rf_next[4], rf_next[5]} = nhl;
            end
            CMD_LD_A_NN: begin
                res_c.acc = ACC_RD8; res_c.addr = q_op.imm; rf_next[7] = mb;
            end
            CMD_LD_NN_A: begin
                res_c.acc = ACC_WR8; res_c.addr = q_op.imm; res_c.wdata = {8'h00, a};
            end
            CMD_LD_A_IOC: begin
                res_c.acc = ACC_RD8; res_c.addr = IO_PAGE | {8'h00, rf_reg[1]};
                rf_next[7] = mb;
            end
            CMD_LD_IOC_A: begin
                res_c.acc = ACC_WR8; res_c.addr = IO_PAGE | {8'h00, rf_reg[1]};
                res_c.wdata = {8'h00, a};
            end
            CMD_LDH_A_N: begin
                res_c.acc = ACC_RD8; res_c.addr = IO_PAGE | {8'h00, ib}; rf_next[7] = mb;
            end
            CMD_LDH_N_A: begin
                res_c.acc = ACC_WR8; res_c.addr = IO_PAGE | {8'h00, ib};
                res_c.wdata = {8'h00, a};
            end
            CMD_LD_RR_NN: begin
                unique case (q_op.pair)
                    2'd0:    {rf_next[0], rf_next[1]} = q_op.imm;
                    2'd1:    {rf_next[2], rf_next[3]} = q_op.imm;
                    2'd2:    {rf_next[4], rf_next[5]} = q_op.imm;
                    default: sp_next = q_op.imm;
                endcase
            end
            CMD_LD_SP_HL: sp_next = hl;
            CMD_LD_HL_SP: begin
                hs = {1'b0, sp_reg[3:0]} + {1'b0, ib[3:0]};
                s  = {1'b0, sp_reg[7:0]} + {1'b0, ib};
                rf_next[6] = {2'b00, hs[4], s[8], 4'h0};
                {rf_next[4], rf_next[5]} = sp_reg + ext;
            end
            CMD_LD_NN_SP: begin
                res_c.acc = ACC_WR16; res_c.addr = q_op.imm; res_c.wdata = sp_reg;
            end
            CMD_PUSH: begin
                sp_next     = sp_reg - 16'd2;
                res_c.acc   = ACC_WR16;
                res_c.addr  = sp_next;
                res_c.wdata = pair_of(rf_reg, q_op.pair);
            end
            CMD_POP: begin
                res_c.acc  = ACC_RD16;
                res_c.addr = sp_reg;
                sp_next    = sp_reg + 16'd2;
                unique case (q_op.pair)
                    2'd0: {rf_next[0], rf_next[1]} = q_op.mdata;
                    2'd1: {rf_next[2], rf_next[3]} = q_op.mdata;
                    2'd2: {rf_next[4], rf_next[5]} = q_op.mdata;
                    default: begin
                        rf_next[7] = q_op.mdata[15:8];
                        rf_next[6] = {q_op.mdata[7:4], 4'h0};
                    end
                endcase
            end
            CMD_ADD, CMD_ADC: begin
                if (mem_src) begin
                    res_c.acc = ACC_RD8; res_c.addr = hl;
                end
                cin = (q_op.cmd == CMD_ADC) && cf;
                s  = {1'b0, a} + {1'b0, v} + {8'h00, cin};
                hs = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'h0, cin};
                rf_next[6] = {s[7:0] == 8'h00, 1'b0, hs[4], s[8], 4'h0};
                rf_next[7] = s[7:0];
            end
            CMD_SUB: begin
                if (mem_src) begin
                    res_c.acc = ACC_RD8; res_c.addr = hl;
                end
                s = {1'b0, a} - {1'b0, v};
                rf_next[6] = {s[7:0] == 8'h00, 1'b1, a[3:0] < v[3:0], a < v, 4'h0};
                rf_next[7] = s[7:0];
            end
            CMD_INC, CMD_DEC: begin
                nw = (q_op.cmd == CMD_INC) ? old + 8'd1 : old - 8'd1;
                rf_next[6] = {nw == 8'h00, q_op.cmd == CMD_DEC,
                              (q_op.cmd == CMD_INC) ? (nw[3:0] == 4'h0) : (old[3:0] == 4'h0),
                              cf, 4'h0};
                if (q_op.dst == SEL_MEM) begin
                    res_c.acc = ACC_WR8; res_c.addr = hl; res_c.wdata = {8'h00, nw};
                end else begin
                    rf_next[q_op.dst] = nw;
                end
            end
            default: ;
        endcase
        res_c.a  = rf_next[7];
        res_c.f  = rf_next[6];
        res_c.bc = {rf_next[0], rf_next[1]};
        res_c.de = {rf_next[2], rf_next[3]};
        res_c.hl = {rf_next[4], rf_next[5]};
        res_c.sp = sp_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 8; i++) rf_reg[i] <= '0;
            sp_reg  <= '0;
            vld_reg <= 1'b0;
        end else begin
            if (fire) begin
                for (int i = 0; i < 8; i++) rf_reg[i] <= rf_next[i];
                sp_reg  <= sp_next;
                res_reg <= res_c;
            end
            if (fire) vld_reg <= 1'b1;
            else if (out_ready) vld_reg <= 1'b0;
        end
    end
endmodule

// ===== src/cpu_register_file_and_alu_execute_core.sv =====
`timescale 1ns / 1ps
// Execute core for a decoded 8-bit CPU instruction subset with its own
// register file (A, F, B, C, D, E, H, L) and stack pointer.
// Slave channel s_*: one decoded instruction per request; s_tdata carries
// command, dst_sel, src_sel, pair_sel, imm_value and the memory read data.
// Master channel m_*: one result per instruction, the memory access it makes
// and every register value after it.
// The front end takes requests into a two-entry queue; the back end executes
// one instruction per cycle, as long as the output register is free or being
// taken, against the register file and holds the result in an output register.
// A request is registered in the queue and then in the output register;
// a new instruction can enter the back end while its last result is taken.
// When the receiver stalls, the output register holds its result and the
// queue fills; s_tready drops only once both queue entries are taken.
// Reset (aresetn low, synchronous) clears all registers and SP to zero and
// empties the queue and output register.
module cpu_register_file_and_alu_execute_core
    import cpuexe_pkg::*;
#(
    parameter int Depth = QueueDepth
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    // command[4:0], dst_sel[7:5], src_sel[11:8], pair_sel[13:12],
    // imm_value[29:14], mem_data[45:30], zero fill
    input  logic [47:0]   s_tdata,
    output logic          m_tvalid,
    input  logic          m_tready,
    // mem_access[2:0], mem_addr[18:3], mem_write_data[34:19], reg_a[42:35],
    // reg_flags[50:43], reg_bc[66:51], reg_de[82:67], reg_hl[98:83],
    // reg_sp[114:99], zero fill
    output logic [119:0]  m_tdata
);
    logic q_valid, q_ready;
    op_t  q_op;
    res_t res;

    // queue decoded requests
    cpuexe_front #(.Depth(Depth)) u_front (
        .aclk, .aresetn,
        .in_valid (s_tvalid), .in_ready (s_tready),
        .in_cmd   (s_tdata[4:0]),   .in_dst   (s_tdata[7:5]),
        .in_src   (s_tdata[11:8]),  .in_pair  (s_tdata[13:12]),
        .in_imm   (s_tdata[29:14]), .in_mdata (s_tdata[45:30]),
        .q_valid, .q_ready, .q_op
    );

    // execute and hold the result
    cpuexe_back u_back (
        .aclk, .aresetn,
        .q_valid, .q_ready, .q_op,
        .out_valid (m_tvalid), .out_ready (m_tready), .out_res (res)
    );

    assign m_tdata = {5'd0, res.sp, res.hl, res.de, res.bc, res.f, res.a,
                      res.wdata, res.addr, res.acc};

    // flag low nibble is always zero
    a_flag_nib: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[46:43] == 4'h0) else $error("flag low nibble set");

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result changed");

    // no access means zero address and data
    a_none: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2:0] == ACC_NONE |-> m_tdata[34:3] == 32'd0)
        else $error("stray access fields");
endmodule
